>>> src/hle_pkg.sv
package hle_pkg;

  localparam int NodeCount = 8;
  localparam int IdxW      = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int IdW       = 3;
  localparam int ClaimW    = 4;
  localparam int TimeW     = 32;
  localparam int MaskW     = 8;
  localparam int DataW     = 32;
  localparam int AddrW     = 3;

  localparam logic signed [ClaimW-1:0] NoneId       = -4'sd1;
  localparam logic [IdW-1:0]           OwnIdReset   = 3'd0;
  localparam logic [TimeW-1:0]         TimeoutReset = 32'd3000;

  typedef enum logic {
    OpHeartbeat,
    OpCheck
  } hle_op_e;

  typedef enum logic {
    RegOwnId,
    RegTimeout
  } hle_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StDrop,
    StAdopt,
    StDecide,
    StOut
  } hle_state_e;

  typedef struct packed {
    logic [IdW-1:0]   own_id;
    logic [TimeW-1:0] timeout;
  } hle_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] last;
    logic [TimeW-1:0] timeout;
  } hle_exp_req_t;

  function automatic logic id_in_table(logic [IdW-1:0] id);
    return 32'(id) < NodeCount;
  endfunction

endpackage

>>> src/hle_in_if.sv
interface hle_in_if;
  import hle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [TimeW-1:0]         current_time;
  logic [IdW-1:0]           sender_node;
  logic signed [ClaimW-1:0] sender_claim;
  logic                     sender_in_range;

  modport source (
    output valid, operation, current_time, sender_node, sender_claim, sender_in_range,
    input  ready
  );

  modport sink (
    input  valid, operation, current_time, sender_node, sender_claim, sender_in_range,
    output ready
  );
endinterface

>>> src/hle_out_if.sv
interface hle_out_if;
  import hle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ClaimW-1:0] leader_belief;
  logic [MaskW-1:0]         alive_mask;
  logic                     leader_changed;
  logic                     heartbeat_accepted;

  modport source (
    output valid, leader_belief, alive_mask, leader_changed, heartbeat_accepted,
    input  ready
  );

  modport sink (
    input  valid, leader_belief, alive_mask, leader_changed, heartbeat_accepted,
    output ready
  );
endinterface

>>> src/hle_cfg_regs.sv
module hle_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [hle_pkg::AddrW-1:0] paddr,
  input  logic [hle_pkg::DataW-1:0] pwdata,
  output logic [hle_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output hle_pkg::hle_cfg_t        cfg_o
);
  import hle_pkg::*;

  logic [IdW-1:0]   own_q, own_d;
  logic [TimeW-1:0] tmo_q, tmo_d;
  hle_reg_e         sel;
  logic             wr_en;

  assign sel    = hle_reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    own_d = own_q;
    tmo_d = tmo_q;
    if (wr_en) begin
      unique case (sel)
        RegOwnId:   own_d = pwdata[IdW-1:0];
        RegTimeout: tmo_d = pwdata[TimeW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegOwnId:   prdata = DataW'(own_q);
      RegTimeout: prdata = DataW'(tmo_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= OwnIdReset;
      tmo_q <= TimeoutReset;
    end else begin
      own_q <= own_d;
      tmo_q <= tmo_d;
    end
  end

  assign cfg_o.own_id  = own_q;
  assign cfg_o.timeout = tmo_q;

endmodule

>>> src/hle_expiry_unit.sv
module hle_expiry_unit (
  input  hle_pkg::hle_exp_req_t req_i,
  output logic                  expired_o
);
  import hle_pkg::*;

  logic [TimeW-1:0] elapsed;

  // wraps modulo 2^32
  assign elapsed   = req_i.now - req_i.last;
  assign expired_o = elapsed > req_i.timeout;

endmodule

>>> src/hle_core.sv
module hle_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hle_pkg::hle_cfg_t cfg_i,
  hle_in_if.sink            in_if,
  hle_out_if.source         out_if
);
  import hle_pkg::*;

  hle_state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q;
  logic [TimeW-1:0] now_q;
  logic acc_q, chg_q, any_q, found_q;
  logic signed [ClaimW-1:0] pick_q;
  logic [IdW-1:0] lowest_q;
  logic signed [ClaimW-1:0] leader_q;

  logic [TimeW-1:0]         last_q  [NodeCount];
  logic signed [ClaimW-1:0] claim_q [NodeCount];
  logic [NodeCount-1:0]     alive_q;

  logic ov_q;
  logic signed [ClaimW-1:0] ob_q;
  logic [MaskW-1:0] om_q;
  logic oc_q, oa_q;

  logic in_ready, walk_last, load_out, accept, hb_ok;
  logic expired, cnt_up, cand_ok;
  logic signed [ClaimW-1:0] in_claim, cand, leader_d;
  logic [MaskW-1:0] mask;
  hle_exp_req_t exp_req;

  function automatic logic id_alive(logic signed [ClaimW-1:0] id, logic [IdW-1:0] own,
                                    logic [NodeCount-1:0] alive);
    logic [IdW-1:0] u;
    u = id[IdW-1:0];
    if (id[ClaimW-1]) return 1'b0;
    if (u == own) return 1'b1;
    return id_in_table(u) && alive[IdxW'(u)];
  endfunction

  hle_expiry_unit u_exp (
    .req_i     (exp_req),
    .expired_o (expired)
  );

  assign exp_req.now     = now_q;
  assign exp_req.last    = last_q[cnt_q];
  assign exp_req.timeout = cfg_i.timeout;

  assign in_claim = in_if.sender_claim[ClaimW-1] ? NoneId : in_if.sender_claim;
  assign accept   = in_if.valid && in_ready;
  assign hb_ok    = (in_if.operation == OpHeartbeat) && in_if.sender_in_range &&
                    (in_if.sender_node != cfg_i.own_id) && id_in_table(in_if.sender_node);

  assign cnt_up  = alive_q[cnt_q] && (int'(cnt_q) != int'(cfg_i.own_id));
  assign cand    = claim_q[cnt_q];
  assign cand_ok = cnt_up && !cand[ClaimW-1] && (cand != leader_q) &&
                   id_alive(cand, cfg_i.own_id, alive_q);

  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < NodeCount) begin : g_in
      assign mask[g] = alive_q[g] && (IdW'(g) != cfg_i.own_id);
    end else begin : g_out
      assign mask[g] = 1'b0;
    end
  end

  always_comb begin
    if (!any_q) begin
      leader_d = leader_q;
    end else if (found_q) begin
      leader_d = pick_q;
    end else if (id_alive(leader_q, cfg_i.own_id, alive_q)) begin
      leader_d = leader_q;
    end else begin
      leader_d = ClaimW'({1'b0, lowest_q});
    end
  end

  // control outputs
  always_comb begin
    in_ready  = (state_q == StIdle);
    walk_last = (cnt_q == IdxW'(NodeCount - 1));
    load_out  = (state_q == StOut) && (!ov_q || out_if.ready);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = (in_if.operation == OpHeartbeat) ? StOut : StDrop;
      end
      StDrop:   if (walk_last) state_d = StAdopt;
      StAdopt:  if (walk_last) state_d = StDecide;
      StDecide: state_d = StOut;
      StOut:    if (load_out) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      now_q    <= '0;
      leader_q <= NoneId;
      alive_q  <= '0;
      ov_q     <= 1'b0;
      ob_q     <= NoneId;
      om_q     <= '0;
      oc_q     <= 1'b0;
      oa_q     <= 1'b0;
      acc_q    <= 1'b0;
      chg_q    <= 1'b0;
      any_q    <= 1'b0;
      found_q  <= 1'b0;
      pick_q   <= NoneId;
      lowest_q <= '0;
      for (int i = 0; i < NodeCount; i++) begin
        last_q[i]  <= '0;
        claim_q[i] <= NoneId;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (accept) begin
            now_q <= in_if.current_time;
            acc_q <= hb_ok;
            chg_q <= 1'b0;
            if (hb_ok) begin
              last_q[IdxW'(in_if.sender_node)]  <= in_if.current_time;
              claim_q[IdxW'(in_if.sender_node)] <= in_claim;
              alive_q[IdxW'(in_if.sender_node)] <= 1'b1;
            end
          end
        end
        StDrop: begin
          if (alive_q[cnt_q] && expired) alive_q[cnt_q] <= 1'b0;
          cnt_q <= walk_last ? '0 : cnt_q + 1'b1;
          any_q    <= 1'b0;
          found_q  <= 1'b0;
          lowest_q <= cfg_i.own_id;
        end
        StAdopt: begin
          if (cnt_up) begin
            any_q <= 1'b1;
            // first peer up is the lowest one
            if (!any_q && (IdW'(cnt_q) < cfg_i.own_id)) lowest_q <= IdW'(cnt_q);
          end
          if (cand_ok && !found_q) begin
            found_q <= 1'b1;
            pick_q  <= cand;
          end
          cnt_q <= walk_last ? '0 : cnt_q + 1'b1;
        end
        StDecide: begin
          leader_q <= leader_d;
          chg_q    <= (leader_d != leader_q);
        end
        StOut: ;
        default: ;
      endcase

      if (load_out) begin
        ov_q <= 1'b1;
        ob_q <= leader_q;
        om_q <= mask;
        oc_q <= chg_q;
        oa_q <= acc_q;
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign in_if.ready               = in_ready;
  assign out_if.valid              = ov_q;
  assign out_if.leader_belief      = ob_q;
  assign out_if.alive_mask         = om_q;
  assign out_if.leader_changed     = oc_q;
  assign out_if.heartbeat_accepted = oa_q;

endmodule

>>> src/heartbeat_leader_election.sv
// Channel | Dir | Word
// in_if   | in  | operation, current_time, sender_node, sender_claim, sender_in_range
// out_if  | out | leader_belief, alive_mask, leader_changed, heartbeat_accepted
// apb     | in  | own_node_id at 0x0, silence_timeout at 0x4
//
// Heartbeat: result registered in StOut, entered straight from StIdle on accept.
// Check: result registered in StOut after a timeout walk (StDrop) through the single expiry
// comparator and a claim walk (StAdopt) over the peer table, one entry per cycle each,
// then a decide state (StDecide).
// Reset clears the table, connected flags, claims and leader belief.
// in_if.ready is high only between items; a word waiting on out_if holds the next
// item in its final cycle until the output register frees.
module heartbeat_leader_election (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  hle_in_if.sink                    in_if,
  hle_out_if.source                 out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hle_pkg::AddrW-1:0] paddr,
  input  logic [hle_pkg::DataW-1:0] pwdata,
  output logic [hle_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import hle_pkg::*;

  hle_cfg_t cfg;

  hle_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hle_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hle_pkg::*;

  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 2 * NodeCount + 6;
  localparam int PhaseCount   = 6;
  localparam int PhaseWords   = 280;

  typedef struct packed {
    hle_op_e                  op;
    logic [TimeW-1:0]         now;
    logic [IdW-1:0]           sender;
    logic signed [ClaimW-1:0] claim;
    logic                     in_range;
  } hle_word_t;

  typedef struct packed {
    logic signed [ClaimW-1:0] belief;
    logic [MaskW-1:0]         mask;
    logic                     changed;
    logic                     accepted;
  } verdict_t;

  typedef struct packed {
    hle_word_t w;
    logic      fixed;
    verdict_t  v;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  hle_in_if  in_bus ();
  hle_out_if out_bus ();

  heartbeat_leader_election i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the peer table and election state
  logic [TimeW-1:0]         heard_at  [NodeCount];
  logic                     linked    [NodeCount];
  logic signed [ClaimW-1:0] peer_vote [NodeCount];
  logic signed [ClaimW-1:0] belief;
  logic [IdW-1:0]           cfg_own;
  logic [TimeW-1:0]         cfg_timeout;

  verdict_t pending_verdicts [$];

  int snd_idle;
  int rcv_idle;
  int fail_count;
  int stall_count;
  int n_results;
  int n_changes;
  int n_taken;
  int n_checks;
  verdict_t seen;
  verdict_t want;

  // reset state, own id 0, timeout 3000
  dir_row_t directed_rows [24] = '{
    '{'{OpCheck,     32'd0,          3'd0, -4'sd1, 1'b1}, 1'b1, '{-4'sd1, 8'h00, 1'b0, 1'b0}},
    '{'{OpHeartbeat, 32'd10,         3'd0,  4'sd3, 1'b1}, 1'b1, '{-4'sd1, 8'h00, 1'b0, 1'b0}},
    '{'{OpHeartbeat, 32'd20,         3'd3,  4'sd3, 1'b0}, 1'b1, '{-4'sd1, 8'h00, 1'b0, 1'b0}},
    '{'{OpHeartbeat, 32'd100,        3'd7,  4'sd7, 1'b1}, 1'b1, '{-4'sd1, 8'h80, 1'b0, 1'b1}},
    '{'{OpHeartbeat, 32'd200,        3'd5, -4'sd8, 1'b1}, 1'b1, '{-4'sd1, 8'ha0, 1'b0, 1'b1}},
    '{'{OpCheck,     32'd300,        3'd0,  4'sd0, 1'b0}, 1'b1, '{ 4'sd7, 8'ha0, 1'b1, 1'b0}},
    '{'{OpHeartbeat, 32'd400,        3'd2,  4'sd0, 1'b1}, 1'b1, '{ 4'sd7, 8'ha4, 1'b0, 1'b1}},
    '{'{OpCheck,     32'd500,        3'd7, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'hffff_fff0,  3'd1, -4'sd2, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'hffff_ffff,  3'd6,  4'sd6, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h0000_0010,  3'd0,  4'sd0, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'h0000_0010,  3'd4,  4'sd4, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h0000_0010,  3'd4,  4'sd4, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_0000,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_0000,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'h8000_0001,  3'd7, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_0002,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'h8000_0003,  3'd3,  4'sd7, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_0004,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'h8000_0005,  3'd6,  4'sd5, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_0006,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpHeartbeat, 32'h8000_1000,  3'd1,  4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_1bb8,  3'd0, -4'sd1, 1'b1}, 1'b0, '0},
    '{'{OpCheck,     32'h8000_1bb9,  3'd0, -4'sd1, 1'b1}, 1'b0, '0}
  };

  always #2 clk_i = ~clk_i;

  function automatic bit peer_live(int id);
    return id < NodeCount && id != int'(cfg_own) && linked[id];
  endfunction

  function automatic bit node_live(logic signed [ClaimW-1:0] id);
    if (id < 0) return 1'b0;
    if (int'(id) == int'(cfg_own)) return 1'b1;
    return peer_live(int'(id));
  endfunction

  function automatic void run_vote();
    int lowest;
    bit any_peer;
    lowest   = int'(cfg_own);
    any_peer = 1'b0;
    for (int i = 0; i < NodeCount; i++) begin
      if (peer_live(i)) begin
        any_peer = 1'b1;
        if (i < lowest) lowest = i;
      end
    end
    if (!any_peer) return;
    // first connected peer, lowest id first, with a fresh claim on a live node wins
    for (int i = 0; i < NodeCount; i++) begin
      if (peer_live(i) && peer_vote[i] >= 0 && peer_vote[i] != belief &&
          node_live(peer_vote[i])) begin
        belief = peer_vote[i];
        return;
      end
    end
    if (belief != NoneId && node_live(belief)) return;
    belief = lowest[ClaimW-1:0];
  endfunction

  function automatic verdict_t next_verdict(hle_word_t w);
    verdict_t v;
    logic signed [ClaimW-1:0] prior;
    v     = '0;
    prior = belief;
    if (w.op == OpHeartbeat) begin
      if (w.in_range && w.sender != cfg_own && int'(w.sender) < NodeCount) begin
        heard_at[w.sender]  = w.now;
        peer_vote[w.sender] = (w.claim < 0) ? NoneId : w.claim;
        linked[w.sender]    = 1'b1;
        v.accepted          = 1'b1;
      end
    end else begin
      for (int i = 0; i < NodeCount; i++) begin
        if (linked[i] && TimeW'(w.now - heard_at[i]) > cfg_timeout) linked[i] = 1'b0;
      end
      run_vote();
      v.changed = (belief != prior);
    end
    for (int i = 0; i < NodeCount && i < MaskW; i++) begin
      if (peer_live(i)) v.mask[i] = 1'b1;
    end
    v.belief = belief;
    return v;
  endfunction

  task automatic push_word(hle_word_t w, bit fixed, verdict_t fixed_v);
    verdict_t v;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    in_bus.valid           <= 1'b1;
    in_bus.operation       <= w.op;
    in_bus.current_time    <= w.now;
    in_bus.sender_node     <= w.sender;
    in_bus.sender_claim    <= w.claim;
    in_bus.sender_in_range <= w.in_range;
    do @(posedge clk_i); while (!in_bus.ready);
    v = next_verdict(w);
    if (w.op == OpCheck) n_checks++;
    if (fixed) v = fixed_v;
    pending_verdicts.insert(pending_verdicts.size(), v);
  endtask

  // drop valid and hold until every result is back and the block has gone quiet
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(hle_reg_e r, logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(r) * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == RegOwnId) cfg_own = val[IdW-1:0];
    else cfg_timeout = val;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen = '{out_bus.leader_belief, out_bus.alive_mask, out_bus.leader_changed,
                 out_bus.heartbeat_accepted};
        n_results++;
        if (seen.changed) n_changes++;
        if (seen.accepted) n_taken++;
        if (pending_verdicts.size() == 0) begin
          $error("result word with nothing expected: belief %0d mask %h", seen.belief, seen.mask);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (seen.belief !== want.belief) begin
            $error("leader_belief: expected %0d, got %0d", want.belief, seen.belief);
            fail_count++;
          end
          if (seen.mask !== want.mask) begin
            $error("alive_mask: expected %h, got %h", want.mask, seen.mask);
            fail_count++;
          end
          if (seen.changed !== want.changed) begin
            $error("leader_changed: expected %0b, got %0b", want.changed, seen.changed);
            fail_count++;
          end
          if (seen.accepted !== want.accepted) begin
            $error("heartbeat_accepted: expected %0b, got %0b", want.accepted, seen.accepted);
            fail_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= StallLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    hle_word_t w;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] span;
    int r;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_bus.valid           = 1'b0;
    in_bus.operation       = 1'b0;
    in_bus.current_time    = '0;
    in_bus.sender_node     = '0;
    in_bus.sender_claim    = '0;
    in_bus.sender_in_range = 1'b0;
    fail_count  = 0;
    stall_count = 0;
    n_results   = 0;
    n_changes   = 0;
    n_taken     = 0;
    n_checks    = 0;
    snd_idle    = 7;
    rcv_idle    = 86;
    for (int i = 0; i < NodeCount; i++) begin
      heard_at[i]  = '0;
      linked[i]    = 1'b0;
      peer_vote[i] = NoneId;
    end
    belief      = NoneId;
    cfg_own     = OwnIdReset;
    cfg_timeout = TimeoutReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      push_word(directed_rows[k].w, directed_rows[k].fixed, directed_rows[k].v);
    end
    now = 32'h8000_2000;

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p / 2)
        0: begin
          snd_idle = 7;
          rcv_idle = 86;
        end
        1: begin
          snd_idle = 86;
          rcv_idle = 7;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      case (p)
        0: begin
          write_reg(RegOwnId, 32'd7);
          write_reg(RegTimeout, 32'd1);
        end
        1: begin
          write_reg(RegOwnId, 32'd0);
          write_reg(RegTimeout, 32'hffff_ffff);
        end
        2: begin
          write_reg(RegOwnId, 32'd3);
          write_reg(RegTimeout, 32'd0);
        end
        3: begin
          write_reg(RegOwnId, DataW'($urandom_range(0, 7)));
          write_reg(RegTimeout, DataW'($urandom_range(10, 1000)));
        end
        4: begin
          write_reg(RegOwnId, DataW'($urandom_range(0, 7)));
          write_reg(RegTimeout, 32'd3000);
        end
        default: begin
          write_reg(RegOwnId, DataW'($urandom_range(0, 7)));
          write_reg(RegTimeout, $urandom());
        end
      endcase

      for (int n = 0; n < PhaseWords; n++) begin
        // mostly small steps against the timeout, some landing on its edge, a few wild jumps
        span = (cfg_timeout < 4000) ? cfg_timeout + 2 : 32'd4000;
        r = $urandom_range(0, 99);
        if (r < 75) now = now + $urandom_range(0, span);
        else if (r < 90) now = now + cfg_timeout + $urandom_range(0, 2);
        else now = $urandom();
        w.op  = ($urandom_range(0, 99) < 30) ? OpCheck : OpHeartbeat;
        w.now = now;
        w.sender = IdW'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 70) w.claim = ClaimW'($urandom_range(0, 7));
        else if (r < 85) w.claim = NoneId;
        else w.claim = ClaimW'($urandom_range(0, 15));
        w.in_range = ($urandom_range(0, 99) < 90);
        if ($urandom_range(0, 49) == 0) begin
          in_bus.valid <= 1'b0;
          do @(posedge clk_i); while (pending_verdicts.size() != 0);
        end
        push_word(w, 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected result words never arrived", pending_verdicts.size());
      fail_count++;
    end
    $display("covered %0d result words: %0d checks, %0d heartbeats taken, %0d leader changes",
             n_results, n_checks, n_taken, n_changes);
    $display("across %0d register settings with both sides stalling and free-running",
             PhaseCount + 1);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
